[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the calibration block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define STC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("same-cycle implication check failed");

// next-cycle implication, disabled in reset
`define STC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("next-cycle implication check failed");

`endif

[rtl/stc_pkg.sv]
// ----------------------------------------------------------------------------
// Sensor calibration package
// Widths, codes and sideband types shared by the calibration datapath.
// ----------------------------------------------------------------------------
package stc_pkg;

  localparam int RAW_W     = 16;
  localparam int TEMP_Y_W  = 10;
  localparam int HUM_Y_W   = 8;
  localparam int Y_W       = 11;
  localparam int D_W       = 17;
  localparam int DMAG_W    = 16;
  localparam int PROD_W    = 28;
  localparam int NUM_W     = 32;
  localparam int MAG_W     = 31;
  localparam int DEN_W     = 22;
  localparam int OUT_W     = 32;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;
  localparam int OP_W      = 2;

  localparam int DEGF_OFFSET = 32;

  typedef enum logic [OP_W-1:0] {
    OP_DEGC = 2'd0,
    OP_DEGF = 2'd1,
    OP_RH   = 2'd2
  } stc_op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TEMP_LOW_DEGC = 3'd0,
    REG_TEMP_HIGH_DEGC = 3'd1,
    REG_TEMP_LOW_RAW  = 3'd2,
    REG_TEMP_HIGH_RAW = 3'd3,
    REG_HUM_LOW_RH    = 3'd4,
    REG_HUM_HIGH_RH   = 3'd5,
    REG_HUM_LOW_RAW   = 3'd6,
    REG_HUM_HIGH_RAW  = 3'd7
  } stc_reg_e;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            err;
    logic            neg;
  } stc_side_t;

endpackage

[rtl/stc_div.sv]
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// Unsigned long division, one quotient bit per register stage, with a
// valid bit and sideband traveling alongside each request.
// ----------------------------------------------------------------------------
module stc_div #(
  parameter int NB = 39
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         in_valid_i,
  input  logic [NB-1:0]                in_w_i,
  input  logic [stc_pkg::DEN_W-1:0]    in_den_i,
  input  stc_pkg::stc_side_t           in_side_i,
  output logic                         out_valid_o,
  output logic [NB-1:0]                out_q_o,
  output stc_pkg::stc_side_t           out_side_o
);

  logic [NB-1:0]             vld_q;
  logic [NB-1:0]             w_q    [NB];
  stc_pkg::stc_side_t        side_q [NB];
  logic [stc_pkg::DEN_W-1:0] rem_q  [NB-1];
  logic [stc_pkg::DEN_W-1:0] den_q  [NB-1];

  for (genvar k = 0; k < NB; k++) begin : g_stage
    logic                      vld_in;
    logic [NB-1:0]             w_in;
    stc_pkg::stc_side_t        side_in;
    logic [stc_pkg::DEN_W-1:0] rem_in;
    logic [stc_pkg::DEN_W-1:0] den_in;
    logic [stc_pkg::DEN_W:0]   trial;
    logic                      ge;

    if (k == 0) begin : g_first
      assign vld_in  = in_valid_i;
      assign w_in    = in_w_i;
      assign side_in = in_side_i;
      assign rem_in  = '0;
      assign den_in  = in_den_i;
    end else begin : g_next
      assign vld_in  = vld_q[k-1];
      assign w_in    = w_q[k-1];
      assign side_in = side_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign den_in  = den_q[k-1];
    end

    assign trial = {rem_in, w_in[NB-1]};
    assign ge    = trial >= {1'b0, den_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        w_q[k]    <= {w_in[NB-2:0], ge};
        side_q[k] <= side_in;
      end
    end

    if (k < NB-1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k] <= ge ? stc_pkg::DEN_W'(trial - {1'b0, den_in})
                         : trial[stc_pkg::DEN_W-1:0];
          den_q[k] <= den_in;
        end
      end
    end
  end

  assign out_valid_o = vld_q[NB-1];
  assign out_q_o     = w_q[NB-1];
  assign out_side_o  = side_q[NB-1];

endmodule

[rtl/sensor_two_point_calibration_top.sv]
// ----------------------------------------------------------------------------
// Two-point sensor calibration
// Linear interpolation of raw samples through two calibration points.
// ----------------------------------------------------------------------------
// Maps each signed raw sample through the two calibration points of the
// selected quantity (degC, degF or %RH) and returns a signed Q(FRAC_BITS)
// result, truncated toward zero and saturated to 32 bits. Equal raw points
// flag calib_error with a zero value; opcode 3 returns all zeros. One request
// is accepted every cycle while in_ready_o is high, which drops only when a
// held result stalls the output; the divider resolves one quotient bit per
// pipeline stage over 31 + FRAC_BITS stages. Four front stages select
// the points and form the products and the numerator; two back stages apply
// sign, offset and saturation. Write the calibration registers only while no
// request is in flight.
`include "assert_macros.svh"

module sensor_two_point_calibration_top #(
  parameter int FRAC_BITS = 8
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [stc_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [stc_pkg::CFG_W-1:0]            cfg_wdata_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [stc_pkg::OP_W-1:0]             opcode_i,
  input  logic signed [stc_pkg::RAW_W-1:0]     raw_sample_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [stc_pkg::OUT_W-1:0]     scaled_value_o,
  output logic                                 calib_error_o,
  output logic                                 saturated_o
);

  localparam int NB = stc_pkg::MAG_W + FRAC_BITS;
  localparam int VW = NB + 2;
  localparam logic signed [VW-1:0] DEGF_OFS = VW'(stc_pkg::DEGF_OFFSET) << FRAC_BITS;
  localparam logic signed [VW-1:0] SAT_MAX  = VW'({1'b0, {(stc_pkg::OUT_W-1){1'b1}}});
  localparam logic signed [VW-1:0] SAT_MIN  = -SAT_MAX - VW'(1);

  // calibration registers
  logic [stc_pkg::TEMP_Y_W-1:0]       temp_low_degc_x8_q, temp_high_degc_x8_q;
  logic signed [stc_pkg::RAW_W-1:0]   temp_low_raw_q, temp_high_raw_q;
  logic [stc_pkg::HUM_Y_W-1:0]        hum_low_rh_x2_q, hum_high_rh_x2_q;
  logic signed [stc_pkg::RAW_W-1:0]   hum_low_raw_q, hum_high_raw_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_low_degc_x8_q  <= '0;
      temp_high_degc_x8_q <= '0;
      temp_low_raw_q      <= '0;
      temp_high_raw_q     <= '0;
      hum_low_rh_x2_q     <= '0;
      hum_high_rh_x2_q    <= '0;
      hum_low_raw_q       <= '0;
      hum_high_raw_q      <= '0;
    end else if (cfg_we_i) begin
      unique case (stc_pkg::stc_reg_e'(cfg_index_i))
        stc_pkg::REG_TEMP_LOW_DEGC: begin
          temp_low_degc_x8_q <= cfg_wdata_i[stc_pkg::TEMP_Y_W-1:0];
        end
        stc_pkg::REG_TEMP_HIGH_DEGC: begin
          temp_high_degc_x8_q <= cfg_wdata_i[stc_pkg::TEMP_Y_W-1:0];
        end
        stc_pkg::REG_TEMP_LOW_RAW:  temp_low_raw_q   <= cfg_wdata_i;
        stc_pkg::REG_TEMP_HIGH_RAW: temp_high_raw_q  <= cfg_wdata_i;
        stc_pkg::REG_HUM_LOW_RH:    hum_low_rh_x2_q  <= cfg_wdata_i[stc_pkg::HUM_Y_W-1:0];
        stc_pkg::REG_HUM_HIGH_RH:   hum_high_rh_x2_q <= cfg_wdata_i[stc_pkg::HUM_Y_W-1:0];
        stc_pkg::REG_HUM_LOW_RAW:   hum_low_raw_q    <= cfg_wdata_i;
        stc_pkg::REG_HUM_HIGH_RAW:  hum_high_raw_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // flow control: one enable for the whole pipe, output register parts the sides
  logic out_valid_q;
  logic fin_valid_q;
  logic take;
  logic en;

  assign take       = !out_valid_q || out_ready_i;
  assign en         = !fin_valid_q || take;
  assign in_ready_o = en;

  // stage 1: select points, form differences
  logic                             s1_valid_q;
  logic [stc_pkg::OP_W-1:0]         s1_op_q;
  logic signed [stc_pkg::Y_W-1:0]   s1_y0_q, s1_dy_q;
  logic signed [stc_pkg::D_W-1:0]   s1_d_q, s1_r_q;
  logic signed [stc_pkg::Y_W-1:0]   sel_y0, sel_y1;
  logic signed [stc_pkg::RAW_W-1:0] sel_x0, sel_x1;

  always_comb begin
    if (opcode_i == stc_pkg::OP_RH) begin
      sel_y0 = stc_pkg::Y_W'(hum_low_rh_x2_q);
      sel_y1 = stc_pkg::Y_W'(hum_high_rh_x2_q);
      sel_x0 = hum_low_raw_q;
      sel_x1 = hum_high_raw_q;
    end else begin
      sel_y0 = stc_pkg::Y_W'(temp_low_degc_x8_q);
      sel_y1 = stc_pkg::Y_W'(temp_high_degc_x8_q);
      sel_x0 = temp_low_raw_q;
      sel_x1 = temp_high_raw_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_op_q <= opcode_i;
      s1_y0_q <= sel_y0;
      s1_dy_q <= sel_y1 - sel_y0;
      s1_d_q  <= stc_pkg::D_W'(sel_x1) - stc_pkg::D_W'(sel_x0);
      s1_r_q  <= stc_pkg::D_W'(raw_sample_i) - stc_pkg::D_W'(sel_x0);
    end
  end

  // stage 2: products, divisor magnitude
  logic                                s2_valid_q;
  logic [stc_pkg::OP_W-1:0]            s2_op_q;
  logic signed [stc_pkg::PROD_W-1:0]   s2_p0_q, s2_p1_q;
  logic [stc_pkg::DEN_W-1:0]           s2_den_q;
  logic                                s2_err_q, s2_dneg_q;
  logic [stc_pkg::D_W-1:0]             d_neg;
  logic [stc_pkg::DMAG_W-1:0]          d_mag;
  logic [stc_pkg::DEN_W-1:0]           den_d;

  assign d_neg = stc_pkg::D_W'(-s1_d_q);
  assign d_mag = s1_d_q[stc_pkg::D_W-1] ? d_neg[stc_pkg::DMAG_W-1:0]
                                        : s1_d_q[stc_pkg::DMAG_W-1:0];

  always_comb begin
    case (s1_op_q)
      stc_pkg::OP_DEGF: den_d = stc_pkg::DEN_W'({d_mag, 5'b0})
                              + stc_pkg::DEN_W'({d_mag, 3'b0});
      stc_pkg::OP_RH:   den_d = stc_pkg::DEN_W'({d_mag, 1'b0});
      default:          den_d = stc_pkg::DEN_W'({d_mag, 3'b0});
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (en) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_op_q   <= s1_op_q;
      s2_p0_q   <= stc_pkg::PROD_W'(s1_y0_q) * stc_pkg::PROD_W'(s1_d_q);
      s2_p1_q   <= stc_pkg::PROD_W'(s1_dy_q) * stc_pkg::PROD_W'(s1_r_q);
      s2_den_q  <= den_d;
      s2_err_q  <= s1_d_q == '0;
      s2_dneg_q <= s1_d_q[stc_pkg::D_W-1];
    end
  end

  // stage 3: numerator sum
  logic                              s3_valid_q;
  logic [stc_pkg::OP_W-1:0]          s3_op_q;
  logic signed [stc_pkg::PROD_W-1:0] s3_n_q;
  logic [stc_pkg::DEN_W-1:0]         s3_den_q;
  logic                              s3_err_q, s3_dneg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else if (en) begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_op_q   <= s2_op_q;
      s3_n_q    <= s2_p0_q + s2_p1_q;
      s3_den_q  <= s2_den_q;
      s3_err_q  <= s2_err_q;
      s3_dneg_q <= s2_dneg_q;
    end
  end

  // stage 4: Fahrenheit scale by nine, magnitude and quotient sign
  logic                             s4_valid_q;
  logic [NB-1:0]                    s4_w_q;
  logic [stc_pkg::DEN_W-1:0]        s4_den_q;
  stc_pkg::stc_side_t               s4_side_q;
  logic signed [stc_pkg::NUM_W-1:0] num_ext, num_a, num_abs;

  assign num_ext = stc_pkg::NUM_W'(s3_n_q);
  assign num_a   = (s3_op_q == stc_pkg::OP_DEGF) ? (num_ext <<< 3) + num_ext : num_ext;
  assign num_abs = num_a[stc_pkg::NUM_W-1] ? -num_a : num_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_valid_q <= 1'b0;
    end else if (en) begin
      s4_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_w_q        <= {num_abs[stc_pkg::MAG_W-1:0], {FRAC_BITS{1'b0}}};
      s4_den_q      <= s3_den_q;
      s4_side_q.op  <= s3_op_q;
      s4_side_q.err <= s3_err_q;
      s4_side_q.neg <= num_a[stc_pkg::NUM_W-1] ^ s3_dneg_q;
    end
  end

  // divider
  logic               div_valid;
  logic [NB-1:0]      div_q;
  stc_pkg::stc_side_t div_side;

  stc_div #(
    .NB (NB)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .in_valid_i  (s4_valid_q),
    .in_w_i      (s4_w_q),
    .in_den_i    (s4_den_q),
    .in_side_i   (s4_side_q),
    .out_valid_o (div_valid),
    .out_q_o     (div_q),
    .out_side_o  (div_side)
  );

  // finish stage: apply sign
  logic signed [VW-1:0] fin_v_q;
  stc_pkg::stc_side_t   fin_side_q;
  logic signed [VW-1:0] q_ext;

  assign q_ext = VW'(div_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_valid_q <= 1'b0;
    end else if (en) begin
      fin_valid_q <= div_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      fin_v_q    <= div_side.neg ? -q_ext : q_ext;
      fin_side_q <= div_side;
    end
  end

  // output stage: offset, saturate, special cases
  logic signed [VW-1:0]            sum;
  logic                            op_ok;
  logic signed [stc_pkg::OUT_W-1:0] val_d;
  logic                            err_d, sat_d;

  assign op_ok = (fin_side_q.op == stc_pkg::OP_DEGC) || (fin_side_q.op == stc_pkg::OP_DEGF)
              || (fin_side_q.op == stc_pkg::OP_RH);
  assign sum   = fin_v_q + ((fin_side_q.op == stc_pkg::OP_DEGF) ? DEGF_OFS : '0);

  always_comb begin
    val_d = '0;
    err_d = 1'b0;
    sat_d = 1'b0;
    if (!op_ok) begin
      val_d = '0;
    end else if (fin_side_q.err) begin
      err_d = 1'b1;
    end else if (sum > SAT_MAX) begin
      val_d = SAT_MAX[stc_pkg::OUT_W-1:0];
      sat_d = 1'b1;
    end else if (sum < SAT_MIN) begin
      val_d = SAT_MIN[stc_pkg::OUT_W-1:0];
      sat_d = 1'b1;
    end else begin
      val_d = sum[stc_pkg::OUT_W-1:0];
    end
  end

  logic signed [stc_pkg::OUT_W-1:0] out_val_q;
  logic                             out_err_q, out_sat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take) begin
      out_valid_q <= fin_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && fin_valid_q) begin
      out_val_q <= val_d;
      out_err_q <= err_d;
      out_sat_q <= sat_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign scaled_value_o = out_val_q;
  assign calib_error_o  = out_err_q;
  assign saturated_o    = out_sat_q;

  `STC_ASSERT_IMP(a_ready_low_only_on_block, clk_i, rst_ni, !in_ready_o, fin_valid_q && out_valid_o && !out_ready_i)
  `STC_ASSERT_NXT(a_fin_holds_on_stall, clk_i, rst_ni, fin_valid_q && out_valid_o && !out_ready_i, fin_valid_q && $stable(fin_v_q))
  `STC_ASSERT_IMP(a_err_gives_zero, clk_i, rst_ni, out_valid_o && calib_error_o, scaled_value_o == '0 && !saturated_o)

endmodule
